FILE: design/sy2r_pkg.sv
// ----------------------------------------------------------------------------
// sy2r_pkg: shared types and constants for the stereo rgb565 converter
// field widths, the input pixel record and the 8.8 fixed-point coefficients
// ----------------------------------------------------------------------------
`default_nettype none

package sy2r_pkg;

	// field widths
	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned PIXEL_W  = 16;
	// signed working width of one channel before the clamp
	localparam int unsigned CH_W     = 18;
	// packed widths of the stream payloads
	localparam int unsigned IN_DATA_W = 6 * SAMPLE_W;
	localparam int unsigned IN_USER_W = 1;

	// 8.8 fixed-point coefficients and offsets
	localparam logic signed [CH_W-1:0] K_RV   = 18'sd357;
	localparam logic signed [CH_W-1:0] R_OFS  = 18'sd45568;
	localparam logic signed [CH_W-1:0] G_OFS  = 18'sd34688;
	localparam logic signed [CH_W-1:0] K_GU   = 18'sd88;
	localparam logic signed [CH_W-1:0] K_GV   = 18'sd182;
	localparam logic signed [CH_W-1:0] K_BU   = 18'sd452;
	localparam logic signed [CH_W-1:0] B_OFS  = 18'sd57728;
	localparam logic signed [CH_W-1:0] CH_MAX = 18'sd65280;

	// one input pixel of the stereo pair
	typedef struct packed {
		logic                odd_column;
		logic [SAMPLE_W-1:0] v_right;
		logic [SAMPLE_W-1:0] u_right;
		logic [SAMPLE_W-1:0] v_left;
		logic [SAMPLE_W-1:0] u_left;
		logic [SAMPLE_W-1:0] y_right;
		logic [SAMPLE_W-1:0] y_left;
	} pix_t;

endpackage

`default_nettype wire

FILE: design/sy2r_convert.sv
// ----------------------------------------------------------------------------
// sy2r_convert: view selection, color conversion and rgb565 packing
// purely combinational, sits between the input and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module sy2r_convert (
	input  wire sy2r_pkg::pix_t                   pix,
	output logic [sy2r_pkg::PIXEL_W-1:0]          rgb565
);

	localparam int unsigned CW = sy2r_pkg::CH_W;
	localparam int unsigned SW = sy2r_pkg::SAMPLE_W;

	function automatic logic [sy2r_pkg::PIXEL_W-1:0] clamp_ch(input logic signed [CW-1:0] x);
		logic [sy2r_pkg::PIXEL_W-1:0] r;
		if (x < 0) begin
			r = '0;
		end else if (x > sy2r_pkg::CH_MAX) begin
			r = sy2r_pkg::CH_MAX[sy2r_pkg::PIXEL_W-1:0];
		end else begin
			r = x[sy2r_pkg::PIXEL_W-1:0];
		end
		return r;
	endfunction

	logic [SW-1:0] y_rb, y_g, u_rb, v_rb, u_g, v_g;
	logic signed [CW-1:0] y_rb_s, y_g_s, u_rb_s, v_rb_s, u_g_s, v_g_s;
	logic signed [CW-1:0] r_raw, g_raw, b_raw;
	logic [sy2r_pkg::PIXEL_W-1:0] r_c, g_c, b_c;

	// even columns: red/blue from left, green from right; odd columns swap
	always_comb begin
		if (pix.odd_column) begin
			y_rb = pix.y_right;
			u_rb = pix.u_right;
			v_rb = pix.v_right;
			y_g  = pix.y_left;
			u_g  = pix.u_left;
			v_g  = pix.v_left;
		end else begin
			y_rb = pix.y_left;
			u_rb = pix.u_left;
			v_rb = pix.v_left;
			y_g  = pix.y_right;
			u_g  = pix.u_right;
			v_g  = pix.v_right;
		end
	end

	// luma in 8.8, chroma as plain integers
	assign y_rb_s = $signed({{(CW-2*SW){1'b0}}, y_rb, {SW{1'b0}}});
	assign y_g_s  = $signed({{(CW-2*SW){1'b0}}, y_g, {SW{1'b0}}});
	assign u_rb_s = $signed({{(CW-SW){1'b0}}, u_rb});
	assign v_rb_s = $signed({{(CW-SW){1'b0}}, v_rb});
	assign u_g_s  = $signed({{(CW-SW){1'b0}}, u_g});
	assign v_g_s  = $signed({{(CW-SW){1'b0}}, v_g});

	assign r_raw = y_rb_s + sy2r_pkg::K_RV * v_rb_s - sy2r_pkg::R_OFS;
	assign g_raw = y_g_s + sy2r_pkg::G_OFS - sy2r_pkg::K_GU * u_g_s - sy2r_pkg::K_GV * v_g_s;
	assign b_raw = y_rb_s + sy2r_pkg::K_BU * u_rb_s - sy2r_pkg::B_OFS;

	assign r_c = clamp_ch(r_raw);
	assign g_c = clamp_ch(g_raw);
	assign b_c = clamp_ch(b_raw);

	assign rgb565 = {r_c[15:11], g_c[15:10], b_c[15:11]};

endmodule

`default_nettype wire

FILE: design/stereo_yuv_to_rgb565_interleave_unit.sv
// ----------------------------------------------------------------------------
// stereo_yuv_to_rgb565_interleave_unit: column-interleaved stereo to rgb565
// converts one pixel of a stereo pair per request into a packed rgb565 word
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while the output side is ready and
// returns one rgb565 word per request, in order, via the input register
// and the result register. This rate comes from the single pass of constant
// multiplies, adds and clamps between the input register and the result
// register; a full pipeline holds two requests. On even columns red and blue
// are built from the left view and green from the right view; odd columns
// swap the views. Each channel is clamped to 0..0xff00 in 8.8 fixed point
// before its top bits are packed as red 15..11, green 10..5, blue 4..0.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_yuv_to_rgb565_interleave_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	// input pixel requests
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// y_left, y_right, u_left, v_left, u_right, v_right (8 bits each)
	input  wire [sy2r_pkg::IN_DATA_W-1:0]     s_tdata,
	// odd_column
	input  wire [sy2r_pkg::IN_USER_W-1:0]     s_tuser,
	// converted pixels
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// rgb565
	output logic [sy2r_pkg::PIXEL_W-1:0]      m_tdata
);

	localparam int unsigned SW = sy2r_pkg::SAMPLE_W;

	// stage 1: registered input pixel
	logic            v_s1;
	sy2r_pkg::pix_t  pix_s1;
	// stage 2: registered result
	logic            v_s2;
	logic [sy2r_pkg::PIXEL_W-1:0] rgb_s2;

	sy2r_pkg::pix_t  pix_in;
	logic [sy2r_pkg::PIXEL_W-1:0] rgb_next;
	logic            adv_s2;
	logic            take_in;

	// unpack the request payload
	assign pix_in.y_left     = s_tdata[0*SW +: SW];
	assign pix_in.y_right    = s_tdata[1*SW +: SW];
	assign pix_in.u_left     = s_tdata[2*SW +: SW];
	assign pix_in.v_left     = s_tdata[3*SW +: SW];
	assign pix_in.u_right    = s_tdata[4*SW +: SW];
	assign pix_in.v_right    = s_tdata[5*SW +: SW];
	assign pix_in.odd_column = s_tuser[0];

	// result register loads when it is empty or being drained
	assign adv_s2   = !v_s2 || m_tready;
	// input register loads when it is empty or moving on
	assign s_tready = !v_s1 || adv_s2;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			pix_s1 <= pix_in;
		end
	end

	sy2r_convert u_convert (
		.pix    (pix_s1),
		.rgb565 (rgb_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			rgb_s2 <= rgb_next;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = rgb_s2;

endmodule

`default_nettype wire

FILE: design/sy2r_checker.sv
// ----------------------------------------------------------------------------
// sy2r_checker: port-level checks for the stereo rgb565 converter
// watches the two stream sides and is bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sy2r_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	input  wire                          s_tready,
	input  wire                          m_tvalid,
	input  wire                          m_tready,
	input  wire [sy2r_pkg::PIXEL_W-1:0]  m_tdata
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// input side only blocks when a result is waiting
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input blocked with no result pending");

	// an accepted request reaches the output once the output side is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
		else $error("accepted request did not produce a result");

endmodule

bind stereo_yuv_to_rgb565_interleave_unit sy2r_checker u_sy2r_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
